// File: sv/cwq_pkg.sv
// ----------------------------------------------------------------------------
// cwq_pkg
// Shared types and constants for the column-wise quality run-length coder.
// ----------------------------------------------------------------------------
package cwq_pkg;

  // sizes
  localparam int COLUMNS    = 256;
  localparam int COL_BITS   = 8;
  localparam int ADDR_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int SYM_BITS   = 8;
  localparam int COUNT_BITS = 32;
  localparam int RUN_BITS   = 32;

  // symbol constants
  localparam logic [SYM_BITS-1:0]   SPACE_SYMBOL  = 8'd32;
  localparam logic [SYM_BITS-1:0]   SYMBOL_OFFSET = 8'd26;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE     = COUNT_BITS'(1);

  // item kinds carried on in_tuser
  localparam logic CMD_SYMBOL = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // one column entry as kept in the run memory
  typedef struct packed {
    logic                  sat;
    logic [COUNT_BITS-1:0] count;
    logic [SYM_BITS-1:0]   symbol;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // decision of the update stage
  typedef struct packed {
    logic wr_en;
    logic set_loaded;
    logic clr_loaded;
    logic emit;
    logic eoc;
  } upd_ctl_t;

endpackage

// File: sv/column_wise_quality_rle.sv
// ----------------------------------------------------------------------------
// column_wise_quality_rle
// Per-column run-length coder for quality symbols, runs kept in one memory.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in      | in  | in_tvalid/tready   | tdata: column, symbol, matched; tuser: cmd
//  out     | out | out_tvalid/tready  | tdata: run_length, run_symbol;
//          |     |                    | tlast: end_of_column; tuser: count_saturated
//  cfg     | in  | cfg_wr_en          | cfg_wr_data: exact_mode
//
//  one word per cycle unless the output stalls; results are registered at the output
//  memory read at accept; the read-modify-write completes when the update stage fires
//  the last write, when to the same column, is forwarded around the memory
//  reset empties every column at once through per-column loaded flags
//  a stalled output holds the update stage, which in turn holds in_tready low
// ----------------------------------------------------------------------------
module column_wise_quality_rle (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // exact_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // column[7:0], symbol[15:8], matched[16], zero pad
  input  logic        in_tuser,      // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // run_length[31:0], run_symbol[39:32]
  output logic        out_tlast,     // end_of_column
  output logic        out_tuser      // count_saturated
);
  import cwq_pkg::*;

  logic                  exact_mode_r;
  logic                  s1_valid_r;
  logic                  s1_cmd_r;
  logic [ADDR_W-1:0]     s1_col_r;
  logic [SYM_BITS-1:0]   s1_sym_r;
  logic                  s1_matched_r;
  logic [COLUMNS-1:0]    loaded_r;
  logic                  fwd_valid_r;
  logic [ADDR_W-1:0]     fwd_col_r;
  entry_t                fwd_entry_r;
  logic                  out_valid_r;
  logic [RUN_BITS-1:0]   out_len_r;
  logic [SYM_BITS-1:0]   out_sym_r;
  logic                  out_eoc_r;
  logic                  out_sat_r;

  logic                  in_accept;
  logic                  s1_fire;
  logic [ENTRY_W-1:0]    rd_data;
  entry_t                cur_entry;
  entry_t                nxt_entry;
  upd_ctl_t              ctl;
  logic [RUN_BITS-1:0]   run_length;
  logic [SYM_BITS-1:0]   run_symbol;
  logic                  run_sat;

  // handshake
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_accept = in_tvalid && in_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exact_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      exact_mode_r <= cfg_wr_data;
    end
  end

  // run memory
  cwq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (COLUMNS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (s1_fire && ctl.wr_en),
    .wr_addr (s1_col_r),
    .wr_data (nxt_entry),
    .rd_en   (in_accept),
    .rd_addr (in_tdata[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // forward the last write over the memory read
  assign cur_entry = (fwd_valid_r && (fwd_col_r == s1_col_r)) ? fwd_entry_r
                                                              : entry_t'(rd_data);

  cwq_update u_update (
    .cmd        (s1_cmd_r),
    .symbol     (s1_sym_r),
    .matched    (s1_matched_r),
    .loaded     (loaded_r[s1_col_r]),
    .exact_mode (exact_mode_r),
    .cur        (cur_entry),
    .nxt        (nxt_entry),
    .ctl        (ctl),
    .run_length (run_length),
    .run_symbol (run_symbol),
    .run_sat    (run_sat)
  );

  // update stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // update stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r     <= in_tuser;
      s1_col_r     <= in_tdata[ADDR_W-1:0];
      s1_sym_r     <= in_tdata[COL_BITS +: SYM_BITS];
      s1_matched_r <= in_tdata[COL_BITS + SYM_BITS];
    end
  end

  // loaded flags and forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= '0;
      fwd_valid_r <= 1'b0;
    end else if (s1_fire) begin
      if (ctl.set_loaded) begin
        loaded_r[s1_col_r] <= 1'b1;
      end else if (ctl.clr_loaded) begin
        loaded_r[s1_col_r] <= 1'b0;
      end
      if (ctl.wr_en) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && ctl.wr_en) begin
      fwd_col_r   <= s1_col_r;
      fwd_entry_r <= nxt_entry;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= ctl.emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && ctl.emit) begin
      out_len_r <= run_length;
      out_sym_r <= run_symbol;
      out_eoc_r <= ctl.eoc;
      out_sat_r <= run_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_sym_r, out_len_r};
  assign out_tlast  = out_eoc_r;
  assign out_tuser  = out_sat_r;

endmodule

// File: sv/cwq_ram.sv
// ----------------------------------------------------------------------------
// cwq_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module cwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/cwq_update.sv
// ----------------------------------------------------------------------------
// cwq_update
// Run decision for one word: load, extend, emit-and-restart or flush.
// ----------------------------------------------------------------------------
module cwq_update (
  input  logic                         cmd,
  input  logic [cwq_pkg::SYM_BITS-1:0] symbol,
  input  logic                         matched,
  input  logic                         loaded,
  input  logic                         exact_mode,
  input  cwq_pkg::entry_t              cur,
  output cwq_pkg::entry_t              nxt,
  output cwq_pkg::upd_ctl_t            ctl,
  output logic [cwq_pkg::RUN_BITS-1:0] run_length,
  output logic [cwq_pkg::SYM_BITS-1:0] run_symbol,
  output logic                         run_sat
);
  import cwq_pkg::*;

  logic                  new_space;
  logic                  old_space;
  logic                  extend;
  logic [COUNT_BITS-1:0] cnt_inc;
  entry_t                fresh;

  // run extension rules
  assign new_space = (symbol == SPACE_SYMBOL);
  assign old_space = (cur.symbol == SPACE_SYMBOL);
  assign extend    = (new_space && old_space)
                   || (!new_space && (symbol == cur.symbol))
                   || (!new_space && !old_space && !exact_mode && matched);

  // saturating count
  assign cnt_inc = (cur.count == COUNT_MAX) ? cur.count : cur.count + COUNT_ONE;

  // entry that starts a new run
  assign fresh.symbol = symbol;
  assign fresh.count  = COUNT_ONE;
  assign fresh.sat    = (COUNT_ONE == COUNT_MAX);

  // emitted fields come from the stored run
  assign run_length = RUN_BITS'(cur.count);
  assign run_symbol = cur.symbol + SYMBOL_OFFSET;
  assign run_sat    = cur.sat;

  always_comb begin
    ctl = '0;
    nxt = cur;
    priority if (cmd == CMD_FLUSH) begin
      ctl.clr_loaded = loaded;
      ctl.emit       = loaded;
      ctl.eoc        = 1'b1;
    end else if (!loaded) begin
      ctl.wr_en      = 1'b1;
      ctl.set_loaded = 1'b1;
      nxt            = fresh;
    end else if (extend) begin
      ctl.wr_en = 1'b1;
      nxt.count = cnt_inc;
      nxt.sat   = cur.sat || (cnt_inc == COUNT_MAX);
    end else begin
      ctl.wr_en = 1'b1;
      ctl.emit  = 1'b1;
      nxt       = fresh;
    end
  end

endmodule

// File: sv/cwq_checker.sv
// ----------------------------------------------------------------------------
// cwq_checker
// Port-level checks for the quality run-length coder, bound to the top level.
// ----------------------------------------------------------------------------
module cwq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out word dropped while stalled");

  // a stalled word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("out payload changed while stalled");

  // every emitted run holds at least one symbol
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:0] != 32'd0)
    else $error("empty run emitted");

  // saturation flag only with a full count
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[31:0] == 32'hFFFF_FFFF)
    else $error("saturation flag with partial count");

  // nothing offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out valid after reset");

endmodule

bind column_wise_quality_rle cwq_checker u_cwq_checker (.*);
